// ===== rtl/core/swls_pkg.sv =====
// ----------------------------------------------------------------------------
// swls_pkg
// Shared types and constants for the sliding window latency statistics block.
// ----------------------------------------------------------------------------
package swls_pkg;

    // item kinds
    localparam logic KIND_PUSH   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // window length register
    localparam int          WIN_LEN_BITS  = 11;
    localparam logic [10:0] WIN_LEN_RESET = 11'd1024;

    // 99th percentile index is floor(99 * n / 100)
    localparam int PCT99_NUM = 99;
    localparam int PCT99_DEN = 100;

    // ceil(2^32 / 100): exact floor division by 100 for dividends below 2^30
    localparam int PCT99_RECIP = 42949673;
    localparam int PCT99_SHIFT = 32;

    typedef logic [WIN_LEN_BITS-1:0] win_len_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] latency;
    } swls_in_t;

    typedef struct packed {
        logic [10:0] sample_count;
        logic        empty_res;
        logic [31:0] mean;
        logic [31:0] minimum;
        logic [31:0] maximum;
        logic [31:0] median;
        logic [31:0] pct_25;
        logic [31:0] pct_75;
        logic [31:0] pct_99;
    } swls_out_t;

endpackage

// ===== rtl/core/swls_ring.sv =====
// ----------------------------------------------------------------------------
// swls_ring
// Sample ring: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module swls_ring #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/swls_div.sv =====
// ----------------------------------------------------------------------------
// swls_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swls_div #(
    parameter int W = 43
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);

    localparam int CNTW = $clog2(W + 1);

    logic [W-1:0]    rem_reg, rem_next;
    logic [W-1:0]    quo_reg, quo_next;
    logic [W-1:0]    dvs_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [W:0]      trial;

    // one trial subtraction per cycle
    always_comb begin
        trial = {rem_reg, quo_reg[W-1]};
        if (trial >= {1'b0, dvs_reg}) begin
            rem_next = W'(trial - {1'b0, dvs_reg});
            quo_next = {quo_reg[W-2:0], 1'b1};
        end else begin
            rem_next = trial[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b0};
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/sliding_window_latency_stats_top.sv =====
// ----------------------------------------------------------------------------
// sliding_window_latency_stats_top
// Keeps a window of latency samples and reports order statistics on request.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item per handshake. kind push writes latency into the
//     ring and gives no result; kind report gives exactly one m_ item.
//   cfg channel: window length, written only while the block is idle; an
//     offered cfg item holds s_ready low. Shrinking drops the oldest samples.
//   Pushes are taken one per cycle while the block is idle and no cfg item is offered.
//   A report with n held samples takes the 99th percentile index from a
//   reciprocal multiply, sweeps the ring once for the sum, runs one serial
//   divide for the mean and then a rank scan: every held sample is compared
//   with all n samples through the single ring read port. s_ready stays low
//   until the result is loaded into the output register; an empty window
//   skips straight to that step.
//   The result waits in an output register; pushes are taken while it waits,
//   a following report finishes and then holds until m_ready.
//   Reset clears the window (no samples held) and sets the length to 1024;
//   the ring needs no clearing, only written entries are ever read.
// ----------------------------------------------------------------------------
module sliding_window_latency_stats_top
    import swls_pkg::*;
#(
    parameter int DEPTH       = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  swls_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output swls_out_t m_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  win_len_t  cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SB = SAMPLE_BITS;
    localparam int SW = SB + CW;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_PCT   = 9'b000000010,
        ST_SUM   = 9'b000000100,
        ST_MEAN  = 9'b000001000,
        ST_CAND  = 9'b000010000,
        ST_CLOAD = 9'b000100000,
        ST_SCAN  = 9'b001000000,
        ST_MATCH = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t          state_reg;
    win_len_t        wl_reg;
    logic [AW-1:0]   wp_reg;
    logic [CW-1:0]   held_reg;
    logic [CW-1:0]   n_reg;
    logic [AW-1:0]   start_reg;
    logic            iss_on_reg;
    logic [CW-1:0]   iss_cnt_reg;
    logic            rd_vld_reg;
    logic [SW-1:0]   sum_reg;
    logic [CW-1:0]   cand_idx_reg;
    logic [SB-1:0]   cand_reg;
    logic [CW-1:0]   lt_reg;
    logic [CW-1:0]   le_reg;
    logic [CW-1:0]   t99_reg;
    logic [SB-1:0]   mean_reg;
    logic [SB-1:0]   min_reg, max_reg, mlo_reg, mhi_reg;
    logic [SB-1:0]   p25_reg, p75_reg, p99_reg;
    logic            m_valid_reg;
    swls_out_t       m_data_reg;

    logic            in_acc;
    logic            cfg_acc;
    logic [CW-1:0]   eff_len;
    logic [CW-1:0]   cfg_len;
    logic [31:0]     start_calc;
    logic            ring_wr;
    logic            ring_rd;
    logic [AW-1:0]   ring_raddr;
    logic [SB-1:0]   ring_rdata;
    logic            div_start;
    logic [SW-1:0]   div_dividend;
    logic [SW-1:0]   div_divisor;
    logic            div_done;
    logic [SW-1:0]   div_quo;
    logic            sweep_done;
    logic [CW-1:0]   t_mid, t_lo, t25, t75, t_max;
    logic [CW+1:0]   n3;
    logic [63:0]     p99_prod;
    logic [SB-1:0]   med;
    logic            out_free;

    // effective window length: zero reads as one, saturate at the depth
    function automatic logic [CW-1:0] eff_of(input win_len_t wl);
        logic [CW-1:0] r;
        if (wl == '0) begin
            r = CW'(1);
        end else if (32'(wl) > 32'(DEPTH)) begin
            r = CW'(DEPTH);
        end else begin
            r = CW'(wl);
        end
        return r;
    endfunction

    // ring address of the k-th oldest held sample
    function automatic logic [AW-1:0] addr_of(input logic [AW-1:0] base,
                                              input logic [CW-1:0] k);
        logic [AW:0] s;
        s = {1'b0, base} + (AW + 1)'(k);
        if (s >= (AW + 1)'(DEPTH)) begin
            s = s - (AW + 1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // handshakes, a configuration write takes precedence over an input item
    assign s_ready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_acc    = s_valid && s_ready;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign eff_len   = eff_of(wl_reg);
    assign cfg_len   = eff_of(cfg_data);
    assign out_free  = !m_valid_reg || m_ready;

    // oldest held slot for a report starting now
    assign start_calc = 32'(wp_reg) + 32'(DEPTH) - 32'(held_reg);

    // ring access
    assign ring_wr    = in_acc && (s_data.kind == KIND_PUSH);
    assign ring_rd    = (state_reg == ST_CAND) || iss_on_reg;
    assign ring_raddr = (state_reg == ST_CAND) ? addr_of(start_reg, cand_idx_reg)
                                               : addr_of(start_reg, iss_cnt_reg);
    assign sweep_done = !iss_on_reg && !rd_vld_reg;

    swls_ring #(
        .DEPTH (DEPTH),
        .WIDTH (SB)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ring_wr),
        .wr_addr (wp_reg),
        .wr_data (SB'(s_data.latency)),
        .rd_en   (ring_rd),
        .rd_addr (ring_raddr),
        .rd_data (ring_rdata)
    );

    // divider for the mean, started once the sum sweep has drained
    always_comb begin
        div_start    = (state_reg == ST_SUM) && sweep_done;
        div_dividend = sum_reg;
        div_divisor  = SW'(n_reg);
    end

    swls_div #(
        .W (SW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // 99th percentile rank: floor(99n / 100) by reciprocal multiplication
    assign p99_prod = 64'(32'(n_reg) * 32'(PCT99_NUM)) * 64'(PCT99_RECIP);

    // target ranks in the sorted order
    always_comb begin
        t_mid = n_reg >> 1;
        t_lo  = n_reg[0] ? t_mid : t_mid - 1'b1;
        t25   = n_reg >> 2;
        n3    = {2'b00, n_reg} + {1'b0, n_reg, 1'b0};
        t75   = CW'(n3 >> 2);
        t_max = n_reg - 1'b1;
    end

    // floor mean of the two middle samples without overflow
    assign med = (mlo_reg >> 1) + (mhi_reg >> 1) + (mlo_reg & mhi_reg & SB'(1));

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wl_reg      <= WIN_LEN_RESET;
            wp_reg      <= '0;
            held_reg    <= '0;
            iss_on_reg  <= 1'b0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            rd_vld_reg <= iss_on_reg;
            if (m_valid && m_ready && !((state_reg == ST_OUT) && out_free)) begin
                m_valid_reg <= 1'b0;
            end
            if (iss_on_reg) begin
                iss_cnt_reg <= iss_cnt_reg + 1'b1;
                if (iss_cnt_reg == n_reg - 1'b1) begin
                    iss_on_reg <= 1'b0;
                end
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (cfg_acc) begin
                        wl_reg <= cfg_data;
                        if (held_reg > cfg_len) begin
                            held_reg <= cfg_len;
                        end
                    end else if (in_acc && (s_data.kind == KIND_PUSH)) begin
                        wp_reg <= (32'(wp_reg) + 32'd1 >= 32'(DEPTH)) ? '0
                                                                      : wp_reg + 1'b1;
                        held_reg <= (held_reg < eff_len) ? held_reg + 1'b1 : eff_len;
                    end else if (in_acc) begin
                        n_reg     <= held_reg;
                        start_reg <= (start_calc >= 32'(DEPTH))
                                     ? AW'(start_calc - 32'(DEPTH)) : AW'(start_calc);
                        state_reg <= (held_reg == '0) ? ST_OUT : ST_PCT;
                    end
                end
                ST_PCT: begin
                    t99_reg     <= CW'(p99_prod >> PCT99_SHIFT);
                    sum_reg     <= '0;
                    iss_on_reg  <= 1'b1;
                    iss_cnt_reg <= '0;
                    state_reg   <= ST_SUM;
                end
                ST_SUM: begin
                    if (rd_vld_reg) begin
                        sum_reg <= sum_reg + SW'(ring_rdata);
                    end
                    if (sweep_done) begin
                        state_reg <= ST_MEAN;
                    end
                end
                ST_MEAN: begin
                    if (div_done) begin
                        mean_reg     <= SB'(div_quo);
                        cand_idx_reg <= '0;
                        state_reg    <= ST_CAND;
                    end
                end
                ST_CAND: begin
                    state_reg <= ST_CLOAD;
                end
                ST_CLOAD: begin
                    cand_reg    <= ring_rdata;
                    lt_reg      <= '0;
                    le_reg      <= '0;
                    iss_on_reg  <= 1'b1;
                    iss_cnt_reg <= '0;
                    state_reg   <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (rd_vld_reg) begin
                        if (ring_rdata < cand_reg) begin
                            lt_reg <= lt_reg + 1'b1;
                        end
                        if (ring_rdata <= cand_reg) begin
                            le_reg <= le_reg + 1'b1;
                        end
                    end
                    if (sweep_done) begin
                        state_reg <= ST_MATCH;
                    end
                end
                ST_MATCH: begin
                    // candidate fills every rank in [lt, le)
                    if (lt_reg == '0)                      min_reg <= cand_reg;
                    if (lt_reg <= t_max && t_max < le_reg) max_reg <= cand_reg;
                    if (lt_reg <= t_lo  && t_lo  < le_reg) mlo_reg <= cand_reg;
                    if (lt_reg <= t_mid && t_mid < le_reg) mhi_reg <= cand_reg;
                    if (lt_reg <= t25   && t25   < le_reg) p25_reg <= cand_reg;
                    if (lt_reg <= t75   && t75   < le_reg) p75_reg <= cand_reg;
                    if (lt_reg <= t99_reg && t99_reg < le_reg) p99_reg <= cand_reg;
                    cand_idx_reg <= cand_idx_reg + 1'b1;
                    state_reg <= (cand_idx_reg == n_reg - 1'b1) ? ST_OUT : ST_CAND;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_OUT) && out_free) begin
            m_data_reg.sample_count <= 11'(n_reg);
            if (n_reg == '0) begin
                m_data_reg.empty_res <= 1'b1;
                m_data_reg.mean      <= '0;
                m_data_reg.minimum   <= '0;
                m_data_reg.maximum   <= '0;
                m_data_reg.median    <= '0;
                m_data_reg.pct_25    <= '0;
                m_data_reg.pct_75    <= '0;
                m_data_reg.pct_99    <= '0;
            end else begin
                m_data_reg.empty_res <= 1'b0;
                m_data_reg.mean      <= 32'(mean_reg);
                m_data_reg.minimum   <= 32'(min_reg);
                m_data_reg.maximum   <= 32'(max_reg);
                m_data_reg.median    <= 32'(med);
                m_data_reg.pct_25    <= 32'(p25_reg);
                m_data_reg.pct_75    <= 32'(p75_reg);
                m_data_reg.pct_99    <= 32'(p99_reg);
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/core/swls_checker.sv =====
// ----------------------------------------------------------------------------
// swls_checker
// Port level checks for the sliding window latency statistics block.
// ----------------------------------------------------------------------------
module swls_checker
    import swls_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input swls_in_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input swls_out_t m_data
);

    // an input item waiting for ready stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input item dropped or changed while waiting");

    // a stalled item stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item dropped or changed while stalled");

    // an empty window reports a zero count, mean, minimum, maximum, median and 99th percentile
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.empty_res |-> m_data.sample_count == 11'd0 &&
        m_data.mean == 32'd0 && m_data.minimum == 32'd0 && m_data.maximum == 32'd0 &&
        m_data.median == 32'd0 && m_data.pct_99 == 32'd0)
        else $error("empty report with non-zero statistics");

    // order statistics are ordered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.empty_res |->
        m_data.minimum <= m_data.pct_25 && m_data.pct_25 <= m_data.median &&
        m_data.median <= m_data.pct_75 && m_data.pct_75 <= m_data.pct_99 &&
        m_data.pct_99 <= m_data.maximum)
        else $error("percentiles out of order");

    // the mean lies within the sample range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.empty_res |->
        m_data.minimum <= m_data.mean && m_data.mean <= m_data.maximum)
        else $error("mean outside sample range");

endmodule

bind sliding_window_latency_stats_top swls_checker u_swls_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
